FILE: hdl/srpd_pkg.sv
// Package for the sync-run payload deframer: transaction types, payload layout
// constants and configuration register indexes. No dependencies.
package srpd_pkg;

    // Payload layout
    localparam int PAYLOAD_BYTES  = 29;
    localparam int PAY_POS_W      = 5;
    localparam int OFF_COUNT      = 2;
    localparam int OFF_ANCHOR     = 3;
    localparam int ANCHOR_STRIDE  = 4;
    localparam int OFF_X          = 19;
    localparam int OFF_Y          = 22;
    localparam int OFF_Z          = 25;

    // Configuration registers
    localparam int CFG_INDEX_W              = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_VALUE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_LENGTH = 2'd1;
    localparam logic [7:0] SYNC_VALUE_RST  = 8'h99;
    localparam logic [2:0] SYNC_LENGTH_RST = 3'd5;

    // Record kinds
    localparam logic KIND_DISTANCE = 1'b0;
    localparam logic KIND_POSITION = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       new_read;
    } byte_item_t;

    typedef struct packed {
        logic        record_kind;
        logic [15:0] node_id;
        logic [15:0] anchor_id;
        logic [15:0] distance_mm;
        logic [23:0] pos_x;
        logic [23:0] pos_y;
        logic [23:0] pos_z;
        logic [7:0]  quality;
        logic [15:0] sequence_res;
        logic        last;
    } rec_item_t;

    typedef struct packed {
        logic [7:0] value;
        logic [2:0] length;
    } sync_cfg_t;

endpackage

FILE: hdl/sync_run_payload_deframer_unit.sv
// Top level of the sync-run payload deframer: configuration registers,
// byte channel handshake, capture and emitter. Depends on srpd_pkg,
// srpd_capture and srpd_emitter.
//
//  channel  | signals                          | role
//  ---------+----------------------------------+-------------------------------
//  byte     | byte_valid byte_ready byte_item  | received bytes in
//  rec      | rec_valid rec_ready rec_item     | distance / position records out
//  cfg      | cfg_valid cfg_ready cfg_index    | register writes (always ready)
//           | cfg_data                         |
//
// One byte is taken per cycle while byte_ready is high; hunt and capture
// state update in that cycle. The closing payload byte loads the frame
// registers; the records (anchor count plus one, at most MAX_ANCHORS+1)
// leave through the output register, one per cycle unless rec_ready stalls it.
// A closing byte is held off while the previous frame's records are still
// being sent; all other bytes are taken regardless of rec_ready.
// Reset clears hunt state, record number and valid flags; the registers come
// up as sync value 0x99 and sync length 5.
module sync_run_payload_deframer_unit #(
    parameter int MAX_ANCHORS = 4
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   byte_valid,
    output logic                                   byte_ready,
    input  srpd_pkg::byte_item_t                   byte_item,
    output logic                                   rec_valid,
    input  logic                                   rec_ready,
    output srpd_pkg::rec_item_t                    rec_item,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [srpd_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [7:0]                             cfg_data
);
    import srpd_pkg::*;

    sync_cfg_t  cfg_reg;
    logic       take;
    logic       frame_near_end;
    logic       frame_done;
    logic       busy;
    logic [7:0] payload [PAYLOAD_BYTES-1];
    logic [7:0] last_byte;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.value  <= SYNC_VALUE_RST;
            cfg_reg.length <= SYNC_LENGTH_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SYNC_VALUE:  cfg_reg.value  <= cfg_data;
                CFG_SYNC_LENGTH: cfg_reg.length <= cfg_data[2:0];
                default:         ;
            endcase
        end
    end

    // byte channel: stall only a possible closing byte while records drain
    assign byte_ready = !(busy && frame_near_end);
    assign take       = byte_valid && byte_ready;

    srpd_capture u_capture (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .take           (take),
        .item           (byte_item),
        .frame_near_end (frame_near_end),
        .frame_done     (frame_done),
        .payload        (payload),
        .last_byte      (last_byte)
    );

    srpd_emitter #(
        .MAX_ANCHORS (MAX_ANCHORS)
    ) u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .frame_done (frame_done),
        .payload    (payload),
        .last_byte  (last_byte),
        .busy       (busy),
        .rec_valid  (rec_valid),
        .rec_ready  (rec_ready),
        .rec_item   (rec_item)
    );

endmodule

FILE: hdl/srpd_capture.sv
// Sync-run hunter and payload capture shift line.
// Depends on srpd_pkg.
module srpd_capture (
    input  logic                clk,
    input  logic                rst_n,
    input  srpd_pkg::sync_cfg_t cfg,
    input  logic                take,
    input  srpd_pkg::byte_item_t item,
    output logic                frame_near_end,
    output logic                frame_done,
    output logic [7:0]          payload [srpd_pkg::PAYLOAD_BYTES-1],
    output logic [7:0]          last_byte
);
    import srpd_pkg::*;

    logic [2:0]           sync_seen_reg, sync_seen_next;
    logic [PAY_POS_W-1:0] capture_pos_reg, capture_pos_next;
    logic [7:0]           shift_reg [PAYLOAD_BYTES-1];
    logic [2:0]           seen_base;
    logic [PAY_POS_W-1:0] pos_base;
    logic                 capturing;
    logic                 pos_at_end;

    // new_read clears the hunt before the byte is looked at
    assign seen_base  = item.new_read ? 3'd0 : sync_seen_reg;
    assign pos_base   = item.new_read ? '0 : capture_pos_reg;
    assign capturing  = (seen_base == cfg.length);
    assign pos_at_end = (pos_base == PAY_POS_W'(PAYLOAD_BYTES - 1));

    // next hunt / capture state
    always_comb
    begin
        if (capturing)
        begin
            if (pos_at_end)
            begin
                sync_seen_next   = 3'd0;
                capture_pos_next = '0;
            end
            else
            begin
                sync_seen_next   = seen_base;
                capture_pos_next = pos_base + PAY_POS_W'(1);
            end
        end
        else
        begin
            // count wraps 7 -> 0 if the length was lowered mid-run
            sync_seen_next   = (item.rx_byte == cfg.value) ? seen_base + 3'd1 : 3'd0;
            capture_pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_seen_reg   <= 3'd0;
            capture_pos_reg <= '0;
        end
        else if (take)
        begin
            sync_seen_reg   <= sync_seen_next;
            capture_pos_reg <= capture_pos_next;
        end
    end

    // payload shift line: the oldest byte ends at index 0
    always_ff @(posedge clk)
    begin
        if (take && capturing)
        begin
            for (int k = 0; k < PAYLOAD_BYTES - 2; k++)
            begin
                shift_reg[k] <= shift_reg[k+1];
            end
            shift_reg[PAYLOAD_BYTES-2] <= item.rx_byte;
        end
    end

    assign payload        = shift_reg;
    assign last_byte      = item.rx_byte;
    assign frame_done     = take && capturing && pos_at_end;
    // next byte may close a frame
    assign frame_near_end = (sync_seen_reg == cfg.length) &&
                            (capture_pos_reg == PAY_POS_W'(PAYLOAD_BYTES - 1));

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        capture_pos_reg < PAY_POS_W'(PAYLOAD_BYTES))
        else $error("capture position ran past the payload");
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> (sync_seen_reg == 3'd0) && (capture_pos_reg == '0))
        else $error("hunt state not cleared after a frame");
    a_hunt_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !capturing) |=> (capture_pos_reg == '0))
        else $error("capture position kept while hunting");

endmodule

FILE: hdl/srpd_emitter.sv
// Frame holding registers and record sequencer with output register.
// Depends on srpd_pkg.
module srpd_emitter #(
    parameter int MAX_ANCHORS = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  frame_done,
    input  logic [7:0]            payload [srpd_pkg::PAYLOAD_BYTES-1],
    input  logic [7:0]            last_byte,
    output logic                  busy,
    output logic                  rec_valid,
    input  logic                  rec_ready,
    output srpd_pkg::rec_item_t   rec_item
);
    import srpd_pkg::*;

    localparam int CNT_W  = $clog2(MAX_ANCHORS + 1);
    localparam int AIDX_W = (MAX_ANCHORS > 1) ? $clog2(MAX_ANCHORS) : 1;

    logic             busy_reg;
    logic [CNT_W-1:0] rec_idx_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      node_id_reg;
    logic [15:0]      anchor_id_reg [MAX_ANCHORS];
    logic [15:0]      distance_reg  [MAX_ANCHORS];
    logic [23:0]      pos_x_reg, pos_y_reg, pos_z_reg;
    logic [7:0]       quality_reg;
    logic [15:0]      seq_reg;
    logic [15:0]      record_number_reg;
    logic             out_valid_reg;
    rec_item_t        out_reg, out_next;
    logic             advance;
    logic             at_last;

    // anchor count clamped to the limit
    always_comb
    begin
        if (payload[OFF_COUNT] > 8'(MAX_ANCHORS))
            count_next = CNT_W'(MAX_ANCHORS);
        else
            count_next = payload[OFF_COUNT][CNT_W-1:0];
    end

    // frame registers, loaded on the closing byte
    always_ff @(posedge clk)
    begin
        if (frame_done)
        begin
            count_reg   <= count_next;
            node_id_reg <= {payload[1], payload[0]};
            for (int i = 0; i < MAX_ANCHORS; i++)
            begin
                anchor_id_reg[i] <= {payload[OFF_ANCHOR + ANCHOR_STRIDE*i + 1],
                                     payload[OFF_ANCHOR + ANCHOR_STRIDE*i]};
                distance_reg[i]  <= {payload[OFF_ANCHOR + ANCHOR_STRIDE*i + 3],
                                     payload[OFF_ANCHOR + ANCHOR_STRIDE*i + 2]};
            end
            pos_x_reg   <= {payload[OFF_X+2], payload[OFF_X+1], payload[OFF_X]};
            pos_y_reg   <= {payload[OFF_Y+2], payload[OFF_Y+1], payload[OFF_Y]};
            pos_z_reg   <= {payload[OFF_Z+2], payload[OFF_Z+1], payload[OFF_Z]};
            quality_reg <= last_byte;
            seq_reg     <= record_number_reg;
        end
    end

    assign at_last = (rec_idx_reg == count_reg);
    assign advance = busy_reg && (!out_valid_reg || rec_ready);

    // build the current record
    always_comb
    begin
        out_next         = '0;
        out_next.node_id = node_id_reg;
        if (at_last)
        begin
            out_next.record_kind  = KIND_POSITION;
            out_next.pos_x        = pos_x_reg;
            out_next.pos_y        = pos_y_reg;
            out_next.pos_z        = pos_z_reg;
            out_next.quality      = quality_reg;
            out_next.sequence_res = seq_reg;
            out_next.last         = 1'b1;
        end
        else
        begin
            out_next.record_kind = KIND_DISTANCE;
            out_next.anchor_id   = anchor_id_reg[rec_idx_reg[AIDX_W-1:0]];
            out_next.distance_mm = distance_reg[rec_idx_reg[AIDX_W-1:0]];
        end
    end

    // sequencer and output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg          <= 1'b0;
            rec_idx_reg       <= '0;
            record_number_reg <= 16'd0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (frame_done)
            begin
                busy_reg          <= 1'b1;
                rec_idx_reg       <= '0;
                record_number_reg <= record_number_reg + 16'd1;
            end
            else if (advance)
            begin
                if (at_last)
                    busy_reg <= 1'b0;
                else
                    rec_idx_reg <= rec_idx_reg + CNT_W'(1);
            end

            if (advance)
                out_valid_reg <= 1'b1;
            else if (rec_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= out_next;
    end

    assign busy      = busy_reg;
    assign rec_valid = out_valid_reg;
    assign rec_item  = out_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |-> !busy_reg)
        else $error("frame closed while records still pending");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rec_idx_reg <= count_reg))
        else $error("record index past anchor count");
    a_last_is_position: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.last == out_reg.record_kind))
        else $error("last flag not on the position record");
    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        !frame_done |=> $stable(record_number_reg))
        else $error("record number moved without a frame");

endmodule
